@@ hw/rtl/bts_pkg.sv @@
`timescale 1ns / 1ps

package bts_pkg;

   localparam int BLOCK_BYTES = 32;
   localparam int WORDS = 16;
   localparam int IDX_W = $clog2(BLOCK_BYTES);
   localparam int BLOCK_BITS = 8 * BLOCK_BYTES;
   localparam int JOB_QUEUE_DEPTH = 2;

   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(BLOCK_BYTES - 1);

   localparam logic [1:0] MODE_TRANSPOSE = 2'd0;
   localparam logic [1:0] MODE_ENCRYPT = 2'd1;
   localparam logic [1:0] MODE_DECRYPT = 2'd2;

   localparam logic [3:0] PAIR_PARTNER [WORDS] = '{
      4'd12, 4'd11, 4'd6, 4'd9, 4'd15, 4'd13, 4'd2, 4'd14,
      4'd10, 4'd3, 4'd8, 4'd1, 4'd0, 4'd5, 4'd7, 4'd4
   };

   // one unit of work for the back end: a full block or a message tail
   typedef struct packed {
      logic is_block;
      logic [IDX_W-1:0] last_idx;
      logic [1:0] mode;
      logic [BLOCK_BITS-1:0] data;
   } job_type;

   function automatic logic [BLOCK_BITS-1:0] scramble_block(
      input logic [BLOCK_BITS-1:0] blk,
      input logic [1:0] mode
   );
      logic [15:0] a [WORDS];
      logic [15:0] b [WORDS];
      logic [15:0] t [WORDS];
      logic [BLOCK_BITS-1:0] res;
      for (int i = 0; i < WORDS; i++) begin
         a[i] = blk[16*i +: 16];
      end
      for (int i = 0; i < WORDS; i++) begin
         b[i] = (mode == MODE_DECRYPT) ? a[PAIR_PARTNER[i]] : a[i];
      end
      for (int i = 0; i < WORDS; i++) begin
         for (int j = 0; j < WORDS; j++) begin
            t[i][j] = b[j][i];
         end
      end
      for (int i = 0; i < WORDS; i++) begin
         res[16*i +: 16] = (mode == MODE_ENCRYPT) ? t[PAIR_PARTNER[i]] : t[i];
      end
      return res;
   endfunction

endpackage

@@ hw/rtl/bts_front.sv @@
`timescale 1ns / 1ps

module bts_front
   import bts_pkg::*;
(
   input  logic clock,
   input  logic reset,
   input  logic accept,
   input  logic [7:0] in_byte,
   input  logic end_of_message,
   input  logic [1:0] mode,
   input  logic queue_full,
   output logic job_push,
   output job_type job
);

   logic [7:0] buf_ff [BLOCK_BYTES];
   logic [IDX_W-1:0] count_ff;
   logic [IDX_W-1:0] count_in;
   logic block_done;

   assign block_done = (count_ff == LAST_IDX);

   always_comb begin
      for (int b = 0; b < BLOCK_BYTES; b++) begin
         job.data[8*b +: 8] = (IDX_W'(b) == count_ff) ? in_byte : buf_ff[b];
      end
      job.is_block = block_done;
      job.last_idx = count_ff;
      job.mode = mode;
   end

   assign job_push = accept && (block_done || end_of_message);

   always_comb begin
      count_in = count_ff;
      if (accept) begin
         count_in = (block_done || end_of_message) ? '0 : count_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         buf_ff[count_ff] <= in_byte;
      end
   end

   assert property (@(posedge clock) disable iff (reset)
      job_push |-> !queue_full)
      else $error("job handed over while the queue is full");

   assert property (@(posedge clock) disable iff (reset)
      (accept && end_of_message) |=> (count_ff == '0))
      else $error("byte count not cleared after end of message");

endmodule

@@ hw/rtl/bts_job_queue.sv @@
`timescale 1ns / 1ps

module bts_job_queue
   import bts_pkg::*;
(
   input  logic clock,
   input  logic reset,
   input  logic push,
   input  job_type push_job,
   output logic full,
   input  logic pop,
   output logic empty,
   output job_type head
);

   localparam int PTR_W = (JOB_QUEUE_DEPTH > 1) ? $clog2(JOB_QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(JOB_QUEUE_DEPTH + 1);
   localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(JOB_QUEUE_DEPTH - 1);
   localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(JOB_QUEUE_DEPTH);

   job_type slot_ff [JOB_QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;

   assign full = (count_ff == CNT_FULL);
   assign empty = (count_ff == '0);
   assign head = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_LAST) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_LAST) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_job;
      end
   end

   assert property (@(posedge clock) disable iff (reset)
      pop |-> !empty)
      else $error("job queue popped while empty");

   assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_FULL)
      else $error("job queue count beyond depth");

endmodule

@@ hw/rtl/bts_back.sv @@
`timescale 1ns / 1ps

module bts_back
   import bts_pkg::*;
(
   input  logic clock,
   input  logic reset,
   input  logic queue_empty,
   input  job_type head,
   output logic queue_pop,
   output logic rsp_empty,
   input  logic rsp_pop,
   output logic [7:0] rsp_out_byte,
   output logic rsp_run_last
);

   logic active_ff, active_in;
   logic is_block_ff, is_block_in;
   logic [IDX_W-1:0] idx_ff, idx_in;
   logic [BLOCK_BITS-1:0] data_ff, data_in;
   logic out_valid_ff, out_valid_in;
   logic [7:0] out_byte_ff, out_byte_in;
   logic run_last_ff, run_last_in;
   logic advance;
   logic last;

   assign last = is_block_ff ? (idx_ff == LAST_IDX) : (idx_ff == '0);
   assign advance = active_ff && (!out_valid_ff || rsp_pop);
   // take the next job as soon as the current one hands over its final byte
   assign queue_pop = !queue_empty && (!active_ff || (advance && last));

   always_comb begin
      active_in = active_ff;
      is_block_in = is_block_ff;
      idx_in = idx_ff;
      data_in = data_ff;
      out_valid_in = out_valid_ff;
      out_byte_in = out_byte_ff;
      run_last_in = run_last_ff;
      if (rsp_pop) begin
         out_valid_in = 1'b0;
      end
      if (advance) begin
         out_valid_in = 1'b1;
         out_byte_in = data_ff[idx_ff*8 +: 8];
         run_last_in = last;
         if (last) begin
            active_in = 1'b0;
         end else if (is_block_ff) begin
            idx_in = idx_ff + 1'b1;
         end else begin
            idx_in = idx_ff - 1'b1;
         end
      end
      if (queue_pop) begin
         active_in = 1'b1;
         is_block_in = head.is_block;
         // a tail goes out newest byte first
         idx_in = head.is_block ? '0 : head.last_idx;
         data_in = head.is_block ? scramble_block(head.data, head.mode) : head.data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         active_ff <= active_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      is_block_ff <= is_block_in;
      idx_ff <= idx_in;
      data_ff <= data_in;
      out_byte_ff <= out_byte_in;
      run_last_ff <= run_last_in;
   end

   assign rsp_empty = !out_valid_ff;
   assign rsp_out_byte = out_byte_ff;
   assign rsp_run_last = run_last_ff;

   assert property (@(posedge clock) disable iff (reset)
      (advance && last) |=> (out_valid_ff && run_last_ff))
      else $error("final byte of a job not marked as run end");

endmodule

@@ hw/rtl/bit_transpose_block_scrambler.sv @@
`timescale 1ns / 1ps

// Byte stream scrambler on 32-byte blocks seen as a 16x16 bit matrix.
// The front end takes one byte per cycle, unless the queue is full, into its
// block buffer; a full block or the end of a message becomes a job in a
// two-entry queue, and req_full rises only while both queue entries are taken.
// The back end transforms a block in the cycle it loads it and then sends
// one result byte per cycle while the result side takes them, through its
// output register; a block or a message tail drains back to back with the
// next job. With the result side always taking, the block keeps one byte
// per cycle on average; the back end's one byte per cycle sets that figure.
// The mode register is sampled when a block completes or a message ends.
module bit_transpose_block_scrambler
   import bts_pkg::*;
(
   input  logic clock,
   input  logic reset,
   input  logic csr_wr_en,
   input  logic [1:0] csr_wr_data,
   input  logic req_push,
   output logic req_full,
   input  logic [7:0] req_in_byte,
   input  logic req_end_of_message,
   output logic rsp_empty,
   input  logic rsp_pop,
   output logic [7:0] rsp_out_byte,
   output logic rsp_run_last
);

   logic [1:0] mode_ff;
   logic req_accept;
   logic job_push;
   job_type job;
   logic queue_full;
   logic queue_empty;
   logic queue_pop;
   job_type head;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= MODE_TRANSPOSE;
      end else if (csr_wr_en) begin
         mode_ff <= csr_wr_data;
      end
   end

   assign req_full = queue_full;
   assign req_accept = req_push && !queue_full;

   bts_front u_front (
      .clock(clock),
      .reset(reset),
      .accept(req_accept),
      .in_byte(req_in_byte),
      .end_of_message(req_end_of_message),
      .mode(mode_ff),
      .queue_full(queue_full),
      .job_push(job_push),
      .job(job)
   );

   bts_job_queue u_queue (
      .clock(clock),
      .reset(reset),
      .push(job_push),
      .push_job(job),
      .full(queue_full),
      .pop(queue_pop),
      .empty(queue_empty),
      .head(head)
   );

   bts_back u_back (
      .clock(clock),
      .reset(reset),
      .queue_empty(queue_empty),
      .head(head),
      .queue_pop(queue_pop),
      .rsp_empty(rsp_empty),
      .rsp_pop(rsp_pop),
      .rsp_out_byte(rsp_out_byte),
      .rsp_run_last(rsp_run_last)
   );

endmodule

@@ verif/tb_bit_transpose_block_scrambler.sv @@
`timescale 1ns / 1ps

module tb_bit_transpose_block_scrambler;
   import bts_pkg::*;

   localparam logic [1:0] MODE_RESERVED = 2'd3;
   localparam int SETTLE_CYCLES = 16;
   localparam int HOLD_CYCLES = 300;
   localparam int RANDOM_ITEMS = 300;

   // word w trades places with SWAP_WITH[w]; every pair is symmetric
   localparam int SWAP_WITH [16] = '{12, 11, 6, 9, 15, 13, 2, 14, 10, 3, 8, 1, 0, 5, 7, 4};

   typedef struct packed {
      logic [7:0] out_byte;
      logic run_last;
   } rsp_type;

   typedef enum logic {ROW_DATA, ROW_MODE} row_kind_type;

   typedef struct packed {
      row_kind_type kind;
      logic [1:0] mode;
      logic [7:0] value;
      logic rnd;
      logic [5:0] count;
      logic eom;
      logic fixed_en;
   } row_type;

   // kind, mode, value, random content, bytes, end flag on last byte, fixed expectation
   localparam row_type DIRECTED [14] = '{
      '{ROW_DATA, MODE_TRANSPOSE, 8'h00, 1'b0, 6'd1, 1'b1, 1'b1},
      '{ROW_DATA, MODE_TRANSPOSE, 8'hff, 1'b0, 6'd1, 1'b1, 1'b1},
      '{ROW_DATA, MODE_TRANSPOSE, 8'hff, 1'b0, 6'd32, 1'b0, 1'b1},
      '{ROW_DATA, MODE_TRANSPOSE, 8'h00, 1'b1, 6'd31, 1'b1, 1'b0},
      '{ROW_MODE, MODE_ENCRYPT, 8'h00, 1'b0, 6'd0, 1'b0, 1'b0},
      '{ROW_DATA, MODE_ENCRYPT, 8'h00, 1'b0, 6'd32, 1'b1, 1'b1},
      '{ROW_DATA, MODE_ENCRYPT, 8'h00, 1'b1, 6'd10, 1'b0, 1'b0},
      '{ROW_MODE, MODE_DECRYPT, 8'h00, 1'b0, 6'd0, 1'b0, 1'b0},
      '{ROW_DATA, MODE_DECRYPT, 8'h00, 1'b1, 6'd22, 1'b0, 1'b0},
      '{ROW_DATA, MODE_DECRYPT, 8'h00, 1'b1, 6'd3, 1'b1, 1'b0},
      '{ROW_MODE, MODE_RESERVED, 8'h00, 1'b0, 6'd0, 1'b0, 1'b0},
      '{ROW_DATA, MODE_RESERVED, 8'h00, 1'b1, 6'd32, 1'b1, 1'b0},
      '{ROW_MODE, MODE_TRANSPOSE, 8'h00, 1'b0, 6'd0, 1'b0, 1'b0},
      '{ROW_DATA, MODE_TRANSPOSE, 8'h5a, 1'b0, 6'd2, 1'b1, 1'b1}
   };

   logic clock;
   logic reset;
   logic csr_wr_en;
   logic [1:0] csr_wr_data;
   logic req_push;
   logic req_full;
   logic [7:0] req_in_byte;
   logic req_end_of_message;
   logic rsp_empty;
   logic rsp_pop;
   logic [7:0] rsp_out_byte;
   logic rsp_run_last;

   // predictor state
   logic [1:0] cur_mode;
   logic [7:0] held [32];
   logic [4:0] fill;
   rsp_type out_bytes_due [$];

   int errors = 0;
   int items_sent = 0;
   int results_seen = 0;
   int blocks_done = 0;
   int tails_done = 0;
   int full_cycles = 0;
   bit send_burst = 1'b0;
   bit recv_burst = 1'b0;
   bit hold_off_req = 1'b0;

   bit_transpose_block_scrambler dut (
      .clock(clock),
      .reset(reset),
      .csr_wr_en(csr_wr_en),
      .csr_wr_data(csr_wr_data),
      .req_push(req_push),
      .req_full(req_full),
      .req_in_byte(req_in_byte),
      .req_end_of_message(req_end_of_message),
      .rsp_empty(rsp_empty),
      .rsp_pop(rsp_pop),
      .rsp_out_byte(rsp_out_byte),
      .rsp_run_last(rsp_run_last)
   );

   initial clock = 1'b0;
   always #5 clock = ~clock;

   initial begin
      #5ms;
      $display("%0t: timeout with %0d results still due", $time, out_bytes_due.size());
      $display("bit_transpose_block_scrambler test failed");
      $finish;
   end

   // take in one accepted byte and queue the expected output of any block or
   // tail that it completes; fixed_en replaces the computed byte values by a value typed into the directed table
   task automatic absorb_byte(input logic [7:0] b, input logic e, input logic fixed_en,
                              input logic [7:0] fixed_val);
      logic [15:0] w [16];
      logic [15:0] t [16];
      rsp_type r;
      int k;
      held[fill] = b;
      k = int'(fill) + 1;
      if (k == 32) begin
         for (int i = 0; i < 16; i++) w[i] = {held[2*i+1], held[2*i]};
         if (cur_mode == MODE_DECRYPT) begin
            for (int i = 0; i < 16; i++) t[i] = w[SWAP_WITH[i]];
            w = t;
         end
         for (int i = 0; i < 16; i++)
            for (int j = 0; j < 16; j++) t[i][j] = w[j][i];
         for (int i = 0; i < 16; i++)
            w[i] = (cur_mode == MODE_ENCRYPT) ? t[SWAP_WITH[i]] : t[i];
         for (int n = 0; n < 32; n++) begin
            r.out_byte = fixed_en ? fixed_val : (n[0] ? w[n/2][15:8] : w[n/2][7:0]);
            r.run_last = (n == 31);
            out_bytes_due.push_back(r);
         end
         fill = '0;
         blocks_done++;
      end else if (e) begin
         for (int n = 0; n < k; n++) begin
            r.out_byte = fixed_en ? fixed_val : held[k-1-n];
            r.run_last = (n == k - 1);
            out_bytes_due.push_back(r);
         end
         fill = '0;
         tails_done++;
      end else begin
         fill = fill + 5'd1;
      end
   endtask

   function automatic logic [7:0] pick_byte();
      int r;
      r = $urandom_range(0, 9);
      if (r == 0) return 8'h00;
      if (r == 1) return 8'hff;
      return 8'($urandom);
   endfunction

   task automatic send_byte(input logic [7:0] b, input logic e, input logic fixed_en,
                            input logic [7:0] fixed_val);
      int gap;
      gap = send_burst ? 0 : $urandom_range(0, 14);
      if (gap != 0) begin
         req_push <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_push <= 1'b1;
      req_in_byte <= b;
      req_end_of_message <= e;
      @(posedge clock);
      while (req_full) begin
         full_cycles++;
         @(posedge clock);
      end
      absorb_byte(b, e, fixed_en, fixed_val);
      items_sent++;
      @(negedge clock);
   endtask

   task automatic send_message(input int len, input logic close);
      for (int i = 0; i < len; i++)
         send_byte(pick_byte(), close && (i == len - 1), 1'b0, 8'h00);
   endtask

   // let every due result drain, then give the back end time to go quiet
   task automatic settle();
      req_push <= 1'b0;
      while (out_bytes_due.size() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic write_mode(input logic [1:0] m);
      settle();
      csr_wr_en <= 1'b1;
      csr_wr_data <= m;
      @(negedge clock);
      csr_wr_en <= 1'b0;
      cur_mode = m;
   endtask

   task automatic check_result(input logic [7:0] ob, input logic rl);
      rsp_type want;
      results_seen++;
      if (out_bytes_due.size() == 0) begin
         $display("%0t: result with none due, out_byte %h run_last %b", $time, ob, rl);
         errors++;
      end else begin
         want = out_bytes_due.pop_front();
         if (ob !== want.out_byte) begin
            $display("%0t: out_byte expected %h got %h", $time, want.out_byte, ob);
            errors++;
         end
         if (rl !== want.run_last) begin
            $display("%0t: run_last expected %b got %b", $time, want.run_last, rl);
            errors++;
         end
      end
   endtask

   // result side
   initial begin
      int gap;
      rsp_pop = 1'b0;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         if (hold_off_req) begin
            hold_off_req = 1'b0;
            rsp_pop <= 1'b0;
            repeat (HOLD_CYCLES) @(negedge clock);
         end
         gap = recv_burst ? 0 : $urandom_range(0, 14);
         if (gap != 0) begin
            rsp_pop <= 1'b0;
            repeat (gap) @(negedge clock);
         end
         rsp_pop <= 1'b1;
         @(posedge clock);
         while (rsp_empty) @(posedge clock);
         check_result(rsp_out_byte, rsp_run_last);
         @(negedge clock);
      end
   end

   // input side and phases
   initial begin
      row_type row;
      int rand_items;
      int phase;
      int n_msgs;
      int pick;
      int len;
      int directed_items;
      logic [1:0] m;
      reset = 1'b1;
      csr_wr_en = 1'b0;
      csr_wr_data = '0;
      req_push = 1'b0;
      req_in_byte = '0;
      req_end_of_message = 1'b0;
      cur_mode = MODE_TRANSPOSE;
      fill = '0;
      rand_items = 0;
      phase = 0;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      foreach (DIRECTED[r]) begin
         row = DIRECTED[r];
         if (row.kind == ROW_MODE) begin
            write_mode(row.mode);
         end else begin
            for (int i = 0; i < int'(row.count); i++)
               send_byte(row.rnd ? pick_byte() : row.value,
                         row.eom && (i == int'(row.count) - 1), row.fixed_en, row.value);
         end
      end
      directed_items = items_sent;

      while (rand_items < RANDOM_ITEMS) begin
         phase++;
         m = (phase <= 4) ? 2'(phase - 1) : 2'($urandom_range(0, 3));
         write_mode(m);
         send_burst = ($urandom_range(0, 3) == 0);
         recv_burst = ($urandom_range(0, 3) == 0);
         if (phase == 1) begin
            // long result-side stall while bytes keep coming, fills the job queue
            send_burst = 1'b1;
            recv_burst = 1'b0;
            hold_off_req = 1'b1;
            len = 128 + $urandom_range(1, 31);
            send_message(len, 1'b1);
            rand_items += len;
         end
         n_msgs = $urandom_range(1, 4);
         for (int n = 0; n < n_msgs; n++) begin
            pick = $urandom_range(0, 9);
            case (pick)
               0, 1, 2, 3: begin
                  len = $urandom_range(1, 31);
                  send_message(len, 1'b1);
               end
               4, 5: begin
                  len = 32;
                  send_message(len, 1'b1);
               end
               6, 7: begin
                  len = 32 + $urandom_range(1, 31);
                  send_message(len, 1'b1);
               end
               8: begin
                  len = 32 * $urandom_range(2, 3);
                  send_message(len, 1'b0);
               end
               default: begin
                  // stop inside a block so the next mode write lands mid block
                  len = $urandom_range(1, 31);
                  send_message(len, 1'b0);
               end
            endcase
            rand_items += len;
         end
      end

      if (fill != 5'd0) send_byte(pick_byte(), 1'b1, 1'b0, 8'h00);
      req_push <= 1'b0;
      while (out_bytes_due.size() != 0) @(posedge clock);
      repeat (64) @(posedge clock);

      $display("run: %0d input transfers (%0d directed), %0d result transfers, %0d phases",
               items_sent, directed_items, results_seen, phase);
      $display("run: %0d blocks, %0d message tails, %0d cycles with the input held off",
               blocks_done, tails_done, full_cycles);
      if (errors == 0 && out_bytes_due.size() == 0) begin
         $display("bit_transpose_block_scrambler test passed");
      end else begin
         $display("bit_transpose_block_scrambler test failed");
      end
      $finish;
   end

endmodule
